@@ design/bba_pkg.sv @@
// Shared types and codes for the buddy block allocator.
package bba_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_GROW,
    S_SPLIT,
    S_REM0,
    S_REM1,
    S_PUSH0,
    S_PUSH1,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE,
    S_MERGE_CHK,
    S_MERGE_ADV,
    S_SHRINK_CHK,
    S_SHRINK_FIN,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SEARCH,
    CMD_TAKE_HEAD,
    CMD_GROW,
    CMD_SPLIT_STEP,
    CMD_ALLOC_FIN,
    CMD_SET_RES,
    CMD_REM_RD,
    CMD_REM_WR,
    CMD_PUSH0,
    CMD_PUSH1,
    CMD_FREE_RD,
    CMD_FREE_TAKE,
    CMD_MERGE_RD,
    CMD_MERGE_ADV,
    CMD_SEL_U,
    CMD_HEAP_DEC,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t    cmd;
    status_t code;
  } dp_ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic op_free;
    logic size_bad;
    logic free_bad;
    logic head_valid;
    logic s_at_top;
    logic split_more;
    logic heap_full;
    logic alloc_bit;
    logic buddy_ok;
    logic shrink_ok;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/buddy_block_allocator_top.sv @@
// Allocate searches the free lists upward by scale, then splits one level at a time;
// free merges with free buddies level by level up to a top block, then may shrink the heap.
// Throughput: one transaction at a time; the next is taken the cycle after the result
// is loaded, and a result not yet taken holds the block.
// Reset: a clearing pass over all TOP_BLOCKS << (MAX_SCALE - MIN_SCALE) units (4096
// at the defaults) runs after rst; no transaction is taken until it ends.
module buddy_block_allocator_top #(
  parameter int MIN_SCALE    = 4,
  parameter int MAX_SCALE    = 12,
  parameter int HEADER_BYTES = 8,
  parameter int TOP_BLOCKS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] alloc_size,
  input  logic [15:0] payload_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_offset,
  output logic [1:0]  status
);

  bba_pkg::dp_ctrl_t   ctrl;
  bba_pkg::dp_status_t st;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .st(st), .ctrl(ctrl)
  );

  bba_dp #(
    .MIN_SCALE(MIN_SCALE), .MAX_SCALE(MAX_SCALE),
    .HEADER_BYTES(HEADER_BYTES), .TOP_BLOCKS(TOP_BLOCKS)
  ) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .st(st),
    .operation(operation), .alloc_size(alloc_size),
    .payload_offset(payload_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_offset(result_offset), .status(status)
  );

endmodule

@@ design/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bba_ctrl.sv @@
// Sequencer for the clearing pass and the allocate, search, split, free, merge and shrink steps.
module bba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bba_pkg::dp_status_t st,
  output bba_pkg::dp_ctrl_t   ctrl
);

  bba_pkg::state_t state, state_next;
  bba_pkg::state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLEAR;
      ret   <= bba_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ctrl.cmd   = bba_pkg::CMD_NONE;
    ctrl.code  = bba_pkg::ST_OK;
    in_ready   = 1'b0;
    case (state)
      bba_pkg::S_CLEAR: begin
        ctrl.cmd = bba_pkg::CMD_CLEAR;
        if (st.clear_done) state_next = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.cmd   = bba_pkg::CMD_LOAD;
          state_next = bba_pkg::S_DECODE;
        end
      end
      bba_pkg::S_DECODE: begin
        if (st.op_free) begin
          if (st.free_bad) begin
            ctrl.cmd   = bba_pkg::CMD_SET_RES;
            ctrl.code  = bba_pkg::ST_BAD_FREE;
            state_next = bba_pkg::S_DONE;
          end else begin
            state_next = bba_pkg::S_FREE_RD;
          end
        end else if (st.size_bad) begin
          ctrl.cmd   = bba_pkg::CMD_SET_RES;
          ctrl.code  = bba_pkg::ST_BAD_SIZE;
          state_next = bba_pkg::S_DONE;
        end else begin
          state_next = bba_pkg::S_SEARCH;
        end
      end
      bba_pkg::S_SEARCH: begin
        if (st.head_valid) begin
          ctrl.cmd   = bba_pkg::CMD_TAKE_HEAD;
          ret_next   = bba_pkg::S_SPLIT;
          state_next = bba_pkg::S_REM0;
        end else if (st.s_at_top) begin
          state_next = bba_pkg::S_GROW;
        end else begin
          ctrl.cmd = bba_pkg::CMD_SEARCH;
        end
      end
      bba_pkg::S_GROW: begin
        if (st.heap_full) begin
          ctrl.cmd   = bba_pkg::CMD_SET_RES;
          ctrl.code  = bba_pkg::ST_NO_MEM;
          state_next = bba_pkg::S_DONE;
        end else begin
          ctrl.cmd   = bba_pkg::CMD_GROW;
          state_next = bba_pkg::S_SPLIT;
        end
      end
      bba_pkg::S_SPLIT: begin
        if (st.split_more) begin
          ctrl.cmd   = bba_pkg::CMD_SPLIT_STEP;
          ret_next   = bba_pkg::S_SPLIT;
          state_next = bba_pkg::S_PUSH0;
        end else begin
          ctrl.cmd   = bba_pkg::CMD_ALLOC_FIN;
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_REM0: begin
        ctrl.cmd   = bba_pkg::CMD_REM_RD;
        state_next = bba_pkg::S_REM1;
      end
      bba_pkg::S_REM1: begin
        ctrl.cmd   = bba_pkg::CMD_REM_WR;
        state_next = ret;
      end
      bba_pkg::S_PUSH0: begin
        ctrl.cmd   = bba_pkg::CMD_PUSH0;
        state_next = bba_pkg::S_PUSH1;
      end
      bba_pkg::S_PUSH1: begin
        ctrl.cmd   = bba_pkg::CMD_PUSH1;
        state_next = ret;
      end
      bba_pkg::S_FREE_RD: begin
        ctrl.cmd   = bba_pkg::CMD_FREE_RD;
        state_next = bba_pkg::S_FREE_CHK;
      end
      bba_pkg::S_FREE_CHK: begin
        if (!st.alloc_bit) begin
          ctrl.cmd   = bba_pkg::CMD_SET_RES;
          ctrl.code  = bba_pkg::ST_BAD_FREE;
          state_next = bba_pkg::S_DONE;
        end else begin
          ctrl.cmd   = bba_pkg::CMD_FREE_TAKE;
          state_next = bba_pkg::S_MERGE;
        end
      end
      bba_pkg::S_MERGE: begin
        if (st.s_at_top) begin
          ctrl.cmd   = bba_pkg::CMD_SEL_U;
          ret_next   = bba_pkg::S_SHRINK_CHK;
          state_next = bba_pkg::S_PUSH0;
        end else begin
          ctrl.cmd   = bba_pkg::CMD_MERGE_RD;
          state_next = bba_pkg::S_MERGE_CHK;
        end
      end
      bba_pkg::S_MERGE_CHK: begin
        if (st.buddy_ok) begin
          ret_next   = bba_pkg::S_MERGE_ADV;
          state_next = bba_pkg::S_REM0;
        end else begin
          ctrl.cmd   = bba_pkg::CMD_SEL_U;
          ret_next   = bba_pkg::S_SHRINK_CHK;
          state_next = bba_pkg::S_PUSH0;
        end
      end
      bba_pkg::S_MERGE_ADV: begin
        ctrl.cmd   = bba_pkg::CMD_MERGE_ADV;
        state_next = bba_pkg::S_MERGE;
      end
      bba_pkg::S_SHRINK_CHK: begin
        if (st.shrink_ok) begin
          ctrl.cmd   = bba_pkg::CMD_SEL_U;
          ret_next   = bba_pkg::S_SHRINK_FIN;
          state_next = bba_pkg::S_REM0;
        end else begin
          ctrl.cmd   = bba_pkg::CMD_SET_RES;
          ctrl.code  = bba_pkg::ST_OK;
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_SHRINK_FIN: begin
        ctrl.cmd   = bba_pkg::CMD_HEAP_DEC;
        state_next = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (st.out_free) begin
          ctrl.cmd   = bba_pkg::CMD_OUT;
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bba_dp.sv @@
// Datapath: block tables, free-list heads, heap size and result register.
module bba_dp #(
  parameter int MIN_SCALE    = 4,
  parameter int MAX_SCALE    = 12,
  parameter int HEADER_BYTES = 8,
  parameter int TOP_BLOCKS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  bba_pkg::dp_ctrl_t   ctrl,
  output bba_pkg::dp_status_t st,
  input  logic                operation,
  input  logic [15:0]         alloc_size,
  input  logic [15:0]         payload_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         result_offset,
  output logic [1:0]          status
);

  localparam int UPB     = MAX_SCALE - MIN_SCALE;
  localparam int TBW     = $clog2(TOP_BLOCKS);
  localparam int UW      = UPB + TBW;
  localparam int NUNITS  = TOP_BLOCKS << UPB;
  localparam int LKW     = UW + 1;
  localparam int NSCALES = UPB + 1;
  localparam int LW      = (NSCALES > 1) ? $clog2(NSCALES) : 1;
  localparam int HW      = $clog2(TOP_BLOCKS + 1);
  localparam logic [LKW-1:0] NIL     = LKW'(NUNITS);
  localparam logic [LW-1:0]  TOP_LVL = LW'(NSCALES - 1);

  logic              op;
  logic              size_bad;
  logic              free_bad;
  logic [LW-1:0]     req;
  logic [LW-1:0]     s;
  logic [UW-1:0]     u;
  logic [UW-1:0]     t;
  logic [HW-1:0]     heap;
  logic [UW-1:0]     clr_cnt;
  logic [15:0]       res_off;
  bba_pkg::status_t  res_st;
  logic [LKW-1:0]    heads [NSCALES];

  logic [LW-1:0]     scale_rd;
  logic [LKW-1:0]    next_rd, prev_rd;
  logic              free_rd, alloc_rd;

  logic              scale_we, next_we, prev_we, free_we, alloc_we;
  logic [UW-1:0]     scale_wa, next_wa, prev_wa, free_wa, alloc_wa, rd_addr;
  logic [LW-1:0]     scale_wd;
  logic [LKW-1:0]    next_wd, prev_wd;
  logic              free_wd, alloc_wd;

  logic [16:0]       total;
  logic [LW-1:0]     req_calc;
  logic              size_bad_calc, free_bad_calc;
  logic [15:0]       start;
  logic [UW-1:0]     bit_s, bit_m1;
  logic [LW-1:0]     s_m1;
  logic [LKW-1:0]    head_s;
  logic [31:0]       heap_units;
  logic [31:0]       alloc_off;

  assign head_s     = heads[s];
  assign s_m1       = s - LW'(1);
  assign bit_s      = UW'(1) << s;
  assign bit_m1     = UW'(1) << s_m1;
  assign heap_units = 32'(heap) << UPB;
  assign alloc_off  = (32'(u) << MIN_SCALE) + 32'(HEADER_BYTES);

  // decode an incoming transaction
  always_comb begin
    logic [LW-1:0] acc;
    acc           = '0;
    total         = 17'(alloc_size) + 17'(HEADER_BYTES);
    for (int l = 0; l < NSCALES - 1; l++) begin
      if ((32'(1) << (MIN_SCALE + l)) < 32'(total)) acc = acc + LW'(1);
    end
    req_calc      = acc;
    size_bad_calc = (alloc_size == 16'd0) ||
                    (32'(alloc_size) > ((32'(1) << MAX_SCALE) - 32'(HEADER_BYTES)));
    start         = payload_offset - 16'(HEADER_BYTES);
    free_bad_calc = (32'(payload_offset) < 32'(HEADER_BYTES)) ||
                    ((32'(start) & ((32'(1) << MIN_SCALE) - 32'd1)) != 32'd0) ||
                    ((32'(start) >> MIN_SCALE) >= heap_units);
  end

  always_comb begin
    st.clear_done = (clr_cnt == UW'(NUNITS - 1));
    st.op_free    = op;
    st.size_bad   = size_bad;
    st.free_bad   = free_bad;
    st.head_valid = (head_s != NIL);
    st.s_at_top   = (s == TOP_LVL);
    st.split_more = (s > req);
    st.heap_full  = (32'(heap) >= 32'(TOP_BLOCKS));
    st.alloc_bit  = alloc_rd;
    st.buddy_ok   = free_rd && (scale_rd == s);
    st.shrink_ok  = (s == TOP_LVL) && (heap != '0) &&
                    (32'(u) == ((32'(heap) - 32'd1) << UPB));
    st.out_free   = !out_valid || out_ready;
  end

  // table write and read port steering
  always_comb begin
    scale_we = 1'b0; scale_wa = t; scale_wd = s;
    next_we  = 1'b0; next_wa  = t; next_wd  = head_s;
    prev_we  = 1'b0; prev_wa  = t; prev_wd  = NIL;
    free_we  = 1'b0; free_wa  = t; free_wd  = 1'b0;
    alloc_we = 1'b0; alloc_wa = u; alloc_wd = 1'b0;
    rd_addr  = t;
    case (ctrl.cmd)
      bba_pkg::CMD_CLEAR: begin
        free_we  = 1'b1; free_wa  = clr_cnt; free_wd = (clr_cnt == '0);
        alloc_we = 1'b1; alloc_wa = clr_cnt;
        scale_we = (clr_cnt == '0); scale_wa = clr_cnt; scale_wd = TOP_LVL;
        next_we  = (clr_cnt == '0); next_wa  = clr_cnt; next_wd  = NIL;
        prev_we  = (clr_cnt == '0); prev_wa  = clr_cnt;
      end
      bba_pkg::CMD_REM_WR: begin
        next_we = (prev_rd != NIL); next_wa = prev_rd[UW-1:0]; next_wd = next_rd;
        prev_we = (next_rd != NIL); prev_wa = next_rd[UW-1:0]; prev_wd = prev_rd;
        free_we = 1'b1;
      end
      bba_pkg::CMD_PUSH0: begin
        scale_we = 1'b1;
        next_we  = 1'b1;
        prev_we  = 1'b1;
        free_we  = 1'b1; free_wd = 1'b1;
      end
      bba_pkg::CMD_PUSH1: begin
        prev_we = (head_s != NIL); prev_wa = head_s[UW-1:0]; prev_wd = LKW'(t);
      end
      bba_pkg::CMD_ALLOC_FIN: begin
        scale_we = 1'b1; scale_wa = u; scale_wd = req;
        free_we  = 1'b1; free_wa  = u;
        alloc_we = 1'b1; alloc_wd = 1'b1;
      end
      bba_pkg::CMD_FREE_RD:   rd_addr  = u;
      bba_pkg::CMD_FREE_TAKE: alloc_we = 1'b1;
      bba_pkg::CMD_MERGE_RD:  rd_addr  = u ^ bit_s;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSCALES; i++) heads[i] <= (i == NSCALES - 1) ? '0 : NIL;
      heap      <= HW'(1);
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.cmd == bba_pkg::CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.cmd)
        bba_pkg::CMD_CLEAR: clr_cnt <= clr_cnt + UW'(1);
        bba_pkg::CMD_LOAD: begin
          op       <= operation;
          size_bad <= size_bad_calc;
          free_bad <= free_bad_calc;
          req      <= req_calc;
          s        <= req_calc;
          u        <= UW'(32'(start) >> MIN_SCALE);
        end
        bba_pkg::CMD_SEARCH: s <= s + LW'(1);
        bba_pkg::CMD_TAKE_HEAD: begin
          u <= head_s[UW-1:0];
          t <= head_s[UW-1:0];
        end
        bba_pkg::CMD_GROW: begin
          u    <= UW'(heap_units);
          heap <= heap + HW'(1);
          s    <= TOP_LVL;
        end
        bba_pkg::CMD_SPLIT_STEP: begin
          s <= s_m1;
          t <= u | bit_m1;
        end
        bba_pkg::CMD_ALLOC_FIN: begin
          res_st  <= bba_pkg::ST_OK;
          res_off <= alloc_off[15:0];
        end
        bba_pkg::CMD_SET_RES: begin
          res_st  <= ctrl.code;
          res_off <= '0;
        end
        bba_pkg::CMD_REM_WR: begin
          if (prev_rd == NIL) heads[s] <= next_rd;
        end
        bba_pkg::CMD_PUSH1: heads[s] <= LKW'(t);
        bba_pkg::CMD_FREE_TAKE: s <= (scale_rd > TOP_LVL) ? '0 : scale_rd;
        bba_pkg::CMD_MERGE_RD:  t <= u ^ bit_s;
        bba_pkg::CMD_MERGE_ADV: begin
          u <= u & ~bit_s;
          s <= s + LW'(1);
        end
        bba_pkg::CMD_SEL_U: t <= u;
        bba_pkg::CMD_HEAP_DEC: begin
          heap    <= heap - HW'(1);
          res_st  <= bba_pkg::ST_OK;
          res_off <= '0;
        end
        bba_pkg::CMD_OUT: begin
          result_offset <= res_off;
          status        <= res_st;
        end
        default: begin
        end
      endcase
    end
  end

  bba_ram #(.WIDTH(LW), .DEPTH(NUNITS)) u_scale_ram (
    .clk(clk), .we(scale_we), .waddr(scale_wa), .wdata(scale_wd),
    .raddr(rd_addr), .rdata(scale_rd)
  );
  bba_ram #(.WIDTH(LKW), .DEPTH(NUNITS)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(rd_addr), .rdata(next_rd)
  );
  bba_ram #(.WIDTH(LKW), .DEPTH(NUNITS)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(rd_addr), .rdata(prev_rd)
  );
  bba_ram #(.WIDTH(1), .DEPTH(NUNITS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd),
    .raddr(rd_addr), .rdata(free_rd)
  );
  bba_ram #(.WIDTH(1), .DEPTH(NUNITS)) u_alloc_ram (
    .clk(clk), .we(alloc_we), .waddr(alloc_wa), .wdata(alloc_wd),
    .raddr(rd_addr), .rdata(alloc_rd)
  );

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    32'(heap) <= 32'(TOP_BLOCKS))
    else $error("heap grew past its top block count");

  a_split_above_req: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == bba_pkg::CMD_SPLIT_STEP |-> s > req)
    else $error("split below requested scale");

  a_alloc_in_heap: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == bba_pkg::CMD_ALLOC_FIN |-> 32'(u) < heap_units)
    else $error("allocated block lies beyond heap top");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == bba_pkg::CMD_OUT |=> out_valid)
    else $error("result not presented after load");

endmodule
